FILE: sv/mahd_pkg.sv
// ----------------------------------------------------------------------------
// mahd_pkg
// Shared types, status codes and header tables for the frame header decoder.
// ----------------------------------------------------------------------------
package mahd_pkg;

  localparam logic [2:0] StatusOk       = 3'd0;
  localparam logic [2:0] StatusNoSync   = 3'd1;
  localparam logic [2:0] StatusFreeFmt  = 3'd2;
  localparam logic [2:0] StatusBadLayer = 3'd3;
  localparam logic [2:0] StatusReserved = 3'd4;

  localparam logic [1:0] ModeJoint = 2'd1;
  localparam logic [1:0] ModeMono  = 2'd3;

  localparam logic [1:0] Rate44k = 2'd0;
  localparam logic [1:0] Rate48k = 2'd1;
  localparam logic [1:0] Rate32k = 2'd2;

  localparam logic [11:0] SyncWord = 12'hfff;

  // ceil(2^26 / 147), exact for the numerator range used here
  localparam int          RecipShift = 26;
  localparam logic [18:0] Recip147   = 19'd456523;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  layer;
    logic [8:0]  kbps;
    logic [15:0] hz;
    logic [1:0]  ridx;
    logic        pad;
    logic [17:0] numer;
    logic [1:0]  channels;
    logic [2:0]  atab;
    logic [4:0]  sblim;
    logic [5:0]  jbound;
    logic        crc;
    logic [1:0]  mode;
    logic [7:0]  side;
  } hdr_entry_t;

  function automatic logic [8:0] kbps_l1(input logic [3:0] idx);
    logic [8:0] r;
    r = (idx == 4'd15) ? 9'd0 : {idx, 5'd0};
    return r;
  endfunction

  function automatic logic [8:0] kbps_l2(input logic [3:0] idx);
    logic [8:0] r;
    case (idx)
      4'd1:    r = 9'd32;
      4'd2:    r = 9'd48;
      4'd3:    r = 9'd56;
      4'd4:    r = 9'd64;
      4'd5:    r = 9'd80;
      4'd6:    r = 9'd96;
      4'd7:    r = 9'd112;
      4'd8:    r = 9'd128;
      4'd9:    r = 9'd160;
      4'd10:   r = 9'd192;
      4'd11:   r = 9'd224;
      4'd12:   r = 9'd256;
      4'd13:   r = 9'd320;
      4'd14:   r = 9'd384;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] rate_hz(input logic [1:0] ridx);
    logic [15:0] r;
    case (ridx)
      Rate44k: r = 16'd44100;
      Rate48k: r = 16'd48000;
      Rate32k: r = 16'd32000;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] alloc_sel(input logic [1:0] ridx, input logic mono,
                                           input logic [3:0] bidx);
    logic [2:0] low_t;
    logic [2:0] high_t;
    logic [2:0] r;
    low_t  = (ridx == Rate32k) ? 3'd3 : 3'd2;
    high_t = (ridx == Rate48k) ? 3'd0 : 3'd1;
    r = 3'd0;
    if (bidx inside {[4'd1:4'd2]}) begin
      r = low_t;
    end else if (bidx inside {[4'd10:4'd14]}) begin
      r = high_t;
    end else if (!mono && (bidx inside {[4'd3:4'd6]})) begin
      r = low_t;
    end else if (mono && (bidx inside {[4'd6:4'd9]})) begin
      r = high_t;
    end
    return r;
  endfunction

  function automatic logic [4:0] sb_limit(input logic [2:0] atab);
    logic [4:0] r;
    case (atab)
      3'd0:    r = 5'd27;
      3'd1:    r = 5'd30;
      3'd2:    r = 5'd8;
      3'd3:    r = 5'd12;
      3'd4:    r = 5'd30;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/mpeg_audio_header_decoder_unit.sv
// ----------------------------------------------------------------------------
// mpeg_audio_header_decoder_unit
// Frame header decoder for layer I and II audio streams.
// ----------------------------------------------------------------------------
// usage: one 32-bit header word goes in on in_valid_i / in_stall_o and one
// result word with status, rates, frame length and layer II table fields
// comes out on out_valid_o / out_stall_i. a word is taken on a clock edge
// with valid high and stall low.
// the front classifies straight into the queue, where the accepted word is
// registered; the back works out the frame length from the queue head and
// registers the result, which raises out_valid_o.
// throughput is one word per cycle unless the receiver stalls; the multiply
// by the reciprocal of the 44.1 kHz rate in the back stage sets the cycle.
// when the receiver stalls, the result is held and the queue fills; once it
// holds QueueDepth words, in_stall_o rises until the receiver takes one.
// reset empties the queue and drops out_valid_o; stored data is not reset.
// ----------------------------------------------------------------------------
module mpeg_audio_header_decoder_unit import mahd_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] header_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [1:0]  layer_o,
  output logic [8:0]  bitrate_kbps_o,
  output logic [15:0] sample_rate_hz_o,
  output logic [1:0]  channels_o,
  output logic [10:0] frame_bytes_o,
  output logic [2:0]  alloc_table_o,
  output logic [4:0]  subband_limit_o,
  output logic [5:0]  joint_bound_o,
  output logic        crc_present_o,
  output logic [1:0]  channel_mode_o,
  output logic [7:0]  side_bits_o
);

  hdr_entry_t front_entry;
  hdr_entry_t q_data;
  hdr_entry_t res;
  logic       q_full;
  logic       q_nempty;
  logic       q_pop;
  logic       push;

  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  mahd_front u_front (
    .header_word_i (header_word_i),
    .entry_o       (front_entry)
  );

  mahd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .nempty_o    (q_nempty),
    .pop_data_o  (q_data)
  );

  mahd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_nempty_i    (q_nempty),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .res_o         (res),
    .frame_bytes_o (frame_bytes_o)
  );

  assign status_o         = res.status;
  assign layer_o          = res.layer;
  assign bitrate_kbps_o   = res.kbps;
  assign sample_rate_hz_o = res.hz;
  assign channels_o       = res.channels;
  assign alloc_table_o    = res.atab;
  assign subband_limit_o  = res.sblim;
  assign joint_bound_o    = res.jbound;
  assign crc_present_o    = res.crc;
  assign channel_mode_o   = res.mode;
  assign side_bits_o      = res.side;

  a_nosync_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatusNoSync |-> layer_o == 2'd0 && channels_o == 2'd0)
    else $error("no-sync result carries header fields");

  a_ok_has_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatusOk |-> sample_rate_hz_o != 16'd0 && frame_bytes_o != 11'd0)
    else $error("good header without rate or length");

  a_err_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StatusOk |-> frame_bytes_o == 11'd0 && bitrate_kbps_o == 9'd0)
    else $error("rejected header with length");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_nempty)
    else $error("queue read while empty");

endmodule

FILE: sv/mahd_front.sv
// ----------------------------------------------------------------------------
// mahd_front
// Classifies one header word and looks up rates, tables and bounds.
// ----------------------------------------------------------------------------
module mahd_front import mahd_pkg::*; (
  input  logic [31:0] header_word_i,
  output hdr_entry_t  entry_o
);

  logic [1:0]  lfield;
  logic [3:0]  bidx;
  logic [1:0]  ridx;
  logic [1:0]  mode;
  logic [1:0]  mext;
  logic [1:0]  lay;
  logic [2:0]  status;
  logic [8:0]  kbps;
  logic [2:0]  atab;
  logic [4:0]  sblim;
  logic [5:0]  jb;
  logic [17:0] numer;
  logic        sync_ok;

  always_comb begin
    lfield  = header_word_i[18:17];
    bidx    = header_word_i[15:12];
    ridx    = header_word_i[11:10];
    mode    = header_word_i[7:6];
    mext    = header_word_i[5:4];
    lay     = (lfield == 2'd0) ? 2'd0 : 2'(3'd4 - {1'b0, lfield});
    sync_ok = (header_word_i[31:20] == SyncWord);

    if (!sync_ok) begin
      status = StatusNoSync;
    end else if (bidx == 4'd0) begin
      status = StatusFreeFmt;
    end else if (lay != 2'd1 && lay != 2'd2) begin
      status = StatusBadLayer;
    end else if (bidx == 4'd15 || ridx == 2'd3) begin
      status = StatusReserved;
    end else begin
      status = StatusOk;
    end

    kbps  = 9'd0;
    atab  = 3'd0;
    sblim = 5'd0;
    jb    = 6'd0;
    numer = 18'd0;
    if (status == StatusOk) begin
      if (lay == 2'd1) begin
        kbps  = kbps_l1(bidx);
        numer = 18'({kbps, 5'd0}) + 18'({kbps, 3'd0});
        jb    = (mode == ModeJoint) ? 6'({mext, 2'b00}) + 6'd4 : 6'd32;
      end else begin
        kbps  = kbps_l2(bidx);
        numer = 18'({kbps, 9'd0}) - 18'({kbps, 5'd0});
        atab  = alloc_sel(ridx, mode == ModeMono, bidx);
        sblim = sb_limit(atab);
        jb    = (mode == ModeJoint) ? 6'({mext, 2'b00}) + 6'd4 : {1'b0, sblim};
      end
    end

    entry_o.status   = status;
    entry_o.layer    = sync_ok ? lay : 2'd0;
    entry_o.kbps     = kbps;
    entry_o.hz       = (status == StatusOk) ? rate_hz(ridx) : 16'd0;
    entry_o.ridx     = ridx;
    entry_o.pad      = header_word_i[9];
    entry_o.numer    = numer;
    entry_o.channels = !sync_ok ? 2'd0 : ((mode == ModeMono) ? 2'd1 : 2'd2);
    entry_o.atab     = atab;
    entry_o.sblim    = sblim;
    entry_o.jbound   = jb;
    entry_o.crc      = sync_ok & ~header_word_i[16];
    entry_o.mode     = sync_ok ? mode : 2'd0;
    entry_o.side     = sync_ok ? {mext, header_word_i[9:8], header_word_i[3:0]} : 8'd0;
  end

endmodule

FILE: sv/mahd_queue.sv
// ----------------------------------------------------------------------------
// mahd_queue
// Small first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module mahd_queue import mahd_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hdr_entry_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       nempty_o,
  output hdr_entry_t pop_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  hdr_entry_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign nempty_o   = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: sv/mahd_back.sv
// ----------------------------------------------------------------------------
// mahd_back
// Works out the frame length and holds the result word for the receiver.
// ----------------------------------------------------------------------------
module mahd_back import mahd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_nempty_i,
  input  hdr_entry_t  q_data_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output hdr_entry_t  res_o,
  output logic [10:0] frame_bytes_o
);

  logic        valid_q;
  hdr_entry_t  res_q;
  logic [10:0] fbytes_q, fbytes_d;
  logic [36:0] prod;
  logic [11:0] base;
  logic [11:0] sum;

  assign q_pop_o = q_nempty_i && (!valid_q || !out_stall_i);

  always_comb begin
    prod = 37'(q_data_i.numer) * 37'(Recip147);
    case (q_data_i.ridx)
      Rate48k: base = (q_data_i.layer == 2'd1) ? 12'(q_data_i.kbps >> 2)
                                               : 12'({q_data_i.kbps, 1'b0}) + 12'(q_data_i.kbps);
      Rate32k: base = (q_data_i.layer == 2'd1)
                      ? 12'((12'({q_data_i.kbps, 1'b0}) + 12'(q_data_i.kbps)) >> 3)
                      : 12'((13'({q_data_i.kbps, 3'd0}) + 13'(q_data_i.kbps)) >> 1);
      default: base = 12'(prod >> RecipShift);
    endcase
    sum = base + 12'(q_data_i.pad);
    if (q_data_i.status != StatusOk) begin
      fbytes_d = 11'd0;
    end else if (q_data_i.layer == 2'd1) begin
      fbytes_d = 11'({sum, 2'b00} - 14'd4);
    end else begin
      fbytes_d = 11'(sum - 12'd4);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || !out_stall_i) begin
      valid_q <= q_nempty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q    <= q_data_i;
      fbytes_q <= fbytes_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign res_o         = res_q;
  assign frame_bytes_o = fbytes_q;

endmodule

FILE: tb/tb_mpeg_audio_header_decoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mpeg_audio_header_decoder_unit
// Self-checking bench for the frame header decoder: a directed table of
// headers, then random header words (mostly in sync), with bursty input,
// patterned output stalls and a scoreboard fed by an in-bench decoder model.
// ----------------------------------------------------------------------------
module tb_mpeg_audio_header_decoder_unit;
  import mahd_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  layer;
    logic [8:0]  kbps;
    logic [15:0] hz;
    logic [1:0]  channels;
    logic [10:0] fbytes;
    logic [2:0]  atab;
    logic [4:0]  sblim;
    logic [5:0]  jbound;
    logic        crc;
    logic [1:0]  mode;
    logic [7:0]  side;
  } hdr_result_t;

  typedef struct {
    logic [31:0] word;
    logic        known;
    hdr_result_t res;
  } hdr_row_t;

  localparam int RandomWords = 1800;
  localparam int WatchdogLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] header_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [1:0]  layer_o;
  logic [8:0]  bitrate_kbps_o;
  logic [15:0] sample_rate_hz_o;
  logic [1:0]  channels_o;
  logic [10:0] frame_bytes_o;
  logic [2:0]  alloc_table_o;
  logic [4:0]  subband_limit_o;
  logic [5:0]  joint_bound_o;
  logic        crc_present_o;
  logic [1:0]  channel_mode_o;
  logic [7:0]  side_bits_o;

  hdr_result_t pending_results[$];
  hdr_result_t known_results[$];
  logic        known_flags[$];
  hdr_row_t    directed_rows[$];
  int          failures = 0;
  int          words_sent = 0;
  int          words_checked = 0;
  int          idle_cycles = 0;
  int          status_seen[5];
  bit          hold_off_req = 1'b0;
  bit          stimulus_done = 1'b0;

  mpeg_audio_header_decoder_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic hdr_result_t decode_header(input logic [31:0] w);
    hdr_result_t r;
    logic [1:0]  lf;
    logic [3:0]  bidx;
    logic [1:0]  ridx;
    logic        pad;
    logic [8:0]  kb;
    int unsigned rate;
    int unsigned len;
    int unsigned tsel;
    r = '0;
    if (w[31:20] != SyncWord) begin
      r.status = StatusNoSync;
      return r;
    end
    lf = w[18:17];
    bidx = w[15:12];
    ridx = w[11:10];
    pad = w[9];
    r.layer = (lf == 2'd0) ? 2'd0 : 2'(3'd4 - {1'b0, lf});
    r.channels = (w[7:6] == ModeMono) ? 2'd1 : 2'd2;
    r.crc = ~w[16];
    r.mode = w[7:6];
    r.side = {w[5:4], w[9:8], w[3:0]};
    if (bidx == 4'd0) r.status = StatusFreeFmt;
    else if (r.layer != 2'd1 && r.layer != 2'd2) r.status = StatusBadLayer;
    else if (bidx == 4'd15 || ridx == 2'd3) r.status = StatusReserved;
    else r.status = StatusOk;
    if (r.status != StatusOk) return r;
    case (ridx)
      Rate44k: rate = 44100;
      Rate48k: rate = 48000;
      default: rate = 32000;
    endcase
    r.hz = 16'(rate);
    if (r.layer == 2'd1) begin
      kb = 9'(32 * bidx);
      len = ((kb * 12000) / rate + pad) * 4 - 4;
      r.jbound = (r.mode == ModeJoint) ? 6'({w[5:4], 2'b00} + 4) : 6'd32;
    end else begin
      case (bidx)
        4'd1: kb = 9'd32;    4'd2: kb = 9'd48;    4'd3: kb = 9'd56;
        4'd4: kb = 9'd64;    4'd5: kb = 9'd80;    4'd6: kb = 9'd96;
        4'd7: kb = 9'd112;   4'd8: kb = 9'd128;   4'd9: kb = 9'd160;
        4'd10: kb = 9'd192;  4'd11: kb = 9'd224;  4'd12: kb = 9'd256;
        4'd13: kb = 9'd320;  default: kb = 9'd384;
      endcase
      len = (kb * 144000) / rate + pad - 4;
      tsel = 0;
      if (r.mode != ModeMono) begin
        if (bidx <= 6) tsel = 2;
        else if (bidx >= 10) tsel = 1;
      end else begin
        if (bidx <= 2) tsel = 2;
        else if (bidx >= 6) tsel = 1;
      end
      if (tsel == 2 && ridx == Rate32k) tsel = 3;
      if (tsel == 1 && ridx == Rate48k) tsel = 0;
      r.atab = 3'(tsel);
      case (tsel)
        0: r.sblim = 5'd27;
        1: r.sblim = 5'd30;
        2: r.sblim = 5'd8;
        default: r.sblim = 5'd12;
      endcase
      r.jbound = (r.mode == ModeJoint) ? 6'({w[5:4], 2'b00} + 4) : 6'(r.sblim);
    end
    r.kbps = kb;
    r.fbytes = 11'(len);
    return r;
  endfunction

  function automatic logic [31:0] random_header();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: ;
      1: w[31:20] = SyncWord;
      default: begin
        w[31:20] = SyncWord;
        w[18:17] = 2'($urandom_range(2, 3));
        w[15:12] = 4'($urandom_range(1, 14));
        w[11:10] = 2'($urandom_range(0, 2));
      end
    endcase
    return w;
  endfunction

  function automatic hdr_row_t make_row(input logic [31:0] w, input logic known,
                                        input hdr_result_t r);
    hdr_row_t row;
    row.word = w;
    row.known = known;
    row.res = r;
    return row;
  endfunction

  task automatic send_word(input logic [31:0] w, input logic known, input hdr_result_t r);
    in_valid_i <= 1'b1;
    header_word_i <= w;
    pending_results.push_back(decode_header(w));
    known_results.push_back(r);
    known_flags.push_back(known);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    if (pending_results.size() != 0) begin
      in_valid_i <= 1'b0;
      while (pending_results.size() != 0) @(negedge clk_i);
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      failures++;
    end
  endtask

  // receiver stall pattern and long hold-off
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        for (hold = 0; hold < 60; hold++) @(negedge clk_i);
        hold_off_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (words_sent % 400 < 100) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    hdr_result_t e;
    hdr_result_t k;
    logic kn;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        failures++;
      end else begin
        e = pending_results.pop_front();
        k = known_results.pop_front();
        kn = known_flags.pop_front();
        if (kn && k != e) begin
          $error("table row disagrees with decoder model for status %0d", k.status);
          failures++;
        end
        check_field("status", e.status, status_o);
        check_field("layer", e.layer, layer_o);
        check_field("bitrate_kbps", e.kbps, bitrate_kbps_o);
        check_field("sample_rate_hz", e.hz, sample_rate_hz_o);
        check_field("channels", e.channels, channels_o);
        check_field("frame_bytes", e.fbytes, frame_bytes_o);
        check_field("alloc_table", e.atab, alloc_table_o);
        check_field("subband_limit", e.sblim, subband_limit_o);
        check_field("joint_bound", e.jbound, joint_bound_o);
        check_field("crc_present", e.crc, crc_present_o);
        check_field("channel_mode", e.mode, channel_mode_o);
        check_field("side_bits", e.side, side_bits_o);
        if (e.status <= StatusReserved) status_seen[e.status]++;
        words_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || stimulus_done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    hdr_result_t r;
    int i;
    int burst;
    int gap;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    r = '0;
    r.status = StatusNoSync;
    directed_rows.push_back(make_row(32'h0000_0000, 1'b1, r));
    directed_rows.push_back(make_row(32'hffe0_0000, 1'b1, r));
    // layer I 448 kbps at 32 kHz, padded: largest layer I frame
    r = '{StatusOk, 2'd1, 9'd448, 16'd32000, 2'd2, 11'd672, 3'd0, 5'd0, 6'd32, 1'b1,
          2'd0, 8'h20};
    directed_rows.push_back(make_row(32'hfff6_ea00, 1'b1, r));
    // layer II 384 kbps at 32 kHz, padded: largest frame
    r = '{StatusOk, 2'd2, 9'd384, 16'd32000, 2'd1, 11'd1725, 3'd1, 5'd30, 6'd30, 1'b0,
          2'd3, 8'hef};
    directed_rows.push_back(make_row(32'hfffd_eaff, 1'b1, r));
    r = '0;
    r.status = StatusFreeFmt; r.layer = 2'd2; r.channels = 2'd2; r.crc = 1'b1;
    directed_rows.push_back(make_row(32'hfffc_0000, 1'b1, r));
    r.status = StatusBadLayer; r.layer = 2'd3;
    directed_rows.push_back(make_row(32'hfff2_1000, 1'b1, r));
    r.layer = 2'd0;
    directed_rows.push_back(make_row(32'hfff0_1000, 1'b1, r));
    r.status = StatusReserved; r.layer = 2'd2;
    directed_rows.push_back(make_row(32'hfffc_f000, 1'b1, r));
    directed_rows.push_back(make_row(32'hfffc_1c00, 1'b1, r));
    // predictor-checked rows: rates, modes, joint bounds, tables
    directed_rows.push_back(make_row(32'hfffd_1000, 1'b0, r));
    directed_rows.push_back(make_row(32'hfffd_1440, 1'b0, r));
    directed_rows.push_back(make_row(32'hfffd_28f0, 1'b0, r));
    directed_rows.push_back(make_row(32'hfffd_6ac0, 1'b0, r));
    directed_rows.push_back(make_row(32'hfffd_a4c0, 1'b0, r));
    directed_rows.push_back(make_row(32'hfffd_e400, 1'b0, r));
    directed_rows.push_back(make_row(32'hfffd_8850, 1'b0, r));
    directed_rows.push_back(make_row(32'hffff_1070, 1'b0, r));
    directed_rows.push_back(make_row(32'hffff_e500, 1'b0, r));
    directed_rows.push_back(make_row(32'hfff7_1000, 1'b0, r));
    directed_rows.push_back(make_row(32'h7ff7_1000, 1'b0, r));
    foreach (directed_rows[j])
      send_word(directed_rows[j].word, directed_rows[j].known, directed_rows[j].res);
    drain();

    // long receiver hold-off while words keep coming
    hold_off_req = 1'b1;
    for (i = 0; i < 20; i++) send_word(random_header(), 1'b0, r);
    drain();

    i = 0;
    while (i < RandomWords) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        send_word(random_header(), 1'b0, r);
        i++;
      end
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      if (i % 600 < 30) drain();
    end
    drain();
    stimulus_done = 1'b1;
    repeat (10) @(posedge clk_i);

    $display("sent %0d header words, checked %0d results", words_sent, words_checked);
    $display("status mix ok/nosync/free/layer/reserved: %0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/mahd_pkg.sv
sv/mahd_front.sv
sv/mahd_queue.sv
sv/mahd_back.sv
sv/mpeg_audio_header_decoder_unit.sv
tb/tb_mpeg_audio_header_decoder_unit.sv
